/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// All checks sample on clk and are off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond implies prop in the same cycle
`define DRS_ASSERT_IMPL(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("drs assertion failed");

// cond implies prop in the next cycle
`define DRS_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("drs assertion failed");

`endif

/* sv/drs_pkg.sv */
`default_nettype none
package drs_pkg;

  // time base
  localparam int TIME_BITS = 32;
  localparam logic [TIME_BITS-1:0] LINGER_MS = 32'd30000;
  // floor(x / 1000) for 32 bit x: (x * RECIP_1000) >> RECIP_SHIFT
  localparam logic [28:0] RECIP_1000 = 29'h10624DD3;
  localparam int RECIP_SHIFT = 38;
  localparam int PROD_BITS = TIME_BITS + 29;
  localparam int SECS_BITS = PROD_BITS - RECIP_SHIFT;
  // warmup window below target, tenths of a degree
  localparam logic signed [12:0] WARM_BAND = 13'sd10;

  // configuration register indexes
  localparam logic [2:0] REG_RUN_SECONDS = 3'd0;
  localparam logic [2:0] REG_MIN_RUN_SECONDS = 3'd1;
  localparam logic [2:0] REG_MAX_RUN_SECONDS = 3'd2;
  localparam logic [2:0] REG_TARGET_AIR = 3'd3;
  localparam logic [2:0] REG_DRY_WINDOWS = 3'd4;
  localparam logic [7:0] DRY_WINDOWS_RESET = 8'd3;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_PAUSE  = 3'd2,
    ACT_RESUME = 3'd3,
    ACT_STOP   = 3'd4,
    ACT_FAULT  = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    MD_IDLE   = 3'd0,
    MD_PRESET = 3'd1,
    MD_MANUAL = 3'd2,
    MD_CONT   = 3'd3,
    MD_CALIB  = 3'd4,
    MD_FAULT  = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_PRECHECK = 4'd1,
    PH_WARMUP   = 4'd2,
    PH_DRYING   = 4'd3,
    PH_HOLD     = 4'd4,
    PH_PAUSED   = 4'd5,
    PH_FINISH   = 4'd6,
    PH_COOLDOWN = 4'd7,
    PH_FAULT    = 4'd8
  } phase_t;

  typedef struct packed {
    action_t              action;
    logic [TIME_BITS-1:0] now_ms;
    logic [2:0]           mode_request;
    logic [3:0]           fault_reason;
    logic                 air_valid;
    logic signed [11:0]   air_tenths;
    logic [7:0]           dry_count;
  } item_t;

  typedef struct packed {
    logic [23:0]        run_seconds;
    logic [23:0]        min_run_seconds;
    logic [23:0]        max_run_seconds;
    logic signed [11:0] target_air_tenths;
    logic [7:0]         dry_windows_needed;
  } cfg_t;

  typedef struct packed {
    mode_t                run_mode;
    phase_t               run_phase;
    logic [3:0]           fault_latch;
    logic [TIME_BITS-1:0] phase_begin_ms;
    logic [TIME_BITS-1:0] run_begin_ms;
    logic [TIME_BITS-1:0] pause_begin_ms;
    phase_t               phase_before_pause;
    logic [23:0]          remaining_secs;
    logic                 run_clock_valid;
    logic [23:0]          lat_run;
    logic [23:0]          lat_min;
    logic [23:0]          lat_max;
    logic signed [11:0]   lat_target;
  } state_t;

  typedef struct packed {
    phase_t      phase_now;
    mode_t       mode_now;
    logic [3:0]  fault_now;
    logic [23:0] seconds_left;
    logic        start_ok;
  } result_t;

endpackage
`default_nettype wire

/* sv/drs_step.sv */
`default_nettype none
// Next state and result for one event word, applied to the current state.
module drs_step (
  input  drs_pkg::state_t  st,
  input  drs_pkg::item_t   item,
  input  drs_pkg::cfg_t    cfg,
  output drs_pkg::state_t  st_next,
  output drs_pkg::result_t res
);

  logic [drs_pkg::TIME_BITS-1:0] run_diff;
  logic [drs_pkg::TIME_BITS-1:0] phase_diff;
  logic [drs_pkg::TIME_BITS-1:0] pause_diff;
  logic [drs_pkg::PROD_BITS-1:0] prod;
  logic [23:0]                   el;
  logic signed [12:0]            air_x;
  logic signed [12:0]            warm_min;
  logic                          warm_ok;
  logic [23:0]                   rem_run;
  logic [23:0]                   rem_max;
  logic                          max_hit;
  logic                          dry_done;
  logic                          start_valid;

  // elapsed drying seconds via reciprocal multiply
  assign run_diff   = item.now_ms - st.run_begin_ms;
  assign phase_diff = item.now_ms - st.phase_begin_ms;
  assign pause_diff = item.now_ms - st.pause_begin_ms;
  assign prod = drs_pkg::PROD_BITS'(run_diff) * drs_pkg::PROD_BITS'(drs_pkg::RECIP_1000);
  assign el = 24'(prod[drs_pkg::PROD_BITS-1:drs_pkg::RECIP_SHIFT]);

  // warmup and drying end tests
  assign air_x    = {item.air_tenths[11], item.air_tenths};
  assign warm_min = {st.lat_target[11], st.lat_target} - drs_pkg::WARM_BAND;
  assign warm_ok  = item.air_valid && (air_x >= warm_min);
  assign rem_run  = (el >= st.lat_run) ? 24'd0 : st.lat_run - el;
  assign rem_max  = (el >= st.lat_max) ? 24'd0 : st.lat_max - el;
  assign max_hit  = (st.lat_max != 24'd0) && (el >= st.lat_max);
  assign dry_done = (el >= st.lat_min) && (item.dry_count >= cfg.dry_windows_needed);

  assign start_valid = (item.mode_request inside {[drs_pkg::MD_PRESET:drs_pkg::MD_CALIB]});

  // event decode
  always_comb begin
    st_next = st;
    res.start_ok = 1'b0;
    case (item.action)
      drs_pkg::ACT_TICK: begin
        case (st.run_phase)
          drs_pkg::PH_PRECHECK: begin
            st_next.run_phase      = drs_pkg::PH_WARMUP;
            st_next.phase_begin_ms = item.now_ms;
          end
          drs_pkg::PH_WARMUP: begin
            if (warm_ok) begin
              st_next.run_phase       = drs_pkg::PH_DRYING;
              st_next.phase_begin_ms  = item.now_ms;
              st_next.run_begin_ms    = item.now_ms;
              st_next.run_clock_valid = 1'b1;
            end
          end
          drs_pkg::PH_DRYING: begin
            if (st.run_mode == drs_pkg::MD_MANUAL) begin
              st_next.remaining_secs = rem_run;
              if (rem_run == 24'd0) begin
                st_next.run_phase      = drs_pkg::PH_FINISH;
                st_next.phase_begin_ms = item.now_ms;
              end
            end else if (st.run_mode == drs_pkg::MD_PRESET) begin
              if (st.lat_max != 24'd0) begin
                st_next.remaining_secs = rem_max;
              end
              if (max_hit || dry_done) begin
                st_next.run_phase      = drs_pkg::PH_HOLD;
                st_next.phase_begin_ms = item.now_ms;
                st_next.remaining_secs = 24'd0;
              end
            end
          end
          drs_pkg::PH_HOLD: begin
            if ((st.run_mode == drs_pkg::MD_PRESET) && (item.dry_count == 8'd0)) begin
              st_next.run_phase       = drs_pkg::PH_DRYING;
              st_next.phase_begin_ms  = item.now_ms;
              st_next.run_begin_ms    = item.now_ms;
              st_next.run_clock_valid = 1'b1;
              st_next.remaining_secs  = st.lat_max;
            end
          end
          drs_pkg::PH_FINISH, drs_pkg::PH_COOLDOWN: begin
            if (phase_diff >= drs_pkg::LINGER_MS) begin
              st_next.run_mode  = drs_pkg::MD_IDLE;
              st_next.run_phase = drs_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      drs_pkg::ACT_START: begin
        if (start_valid) begin
          res.start_ok            = 1'b1;
          st_next.lat_run         = cfg.run_seconds;
          st_next.lat_min         = cfg.min_run_seconds;
          st_next.lat_max         = cfg.max_run_seconds;
          st_next.lat_target      = cfg.target_air_tenths;
          st_next.run_mode        = drs_pkg::mode_t'(item.mode_request);
          st_next.run_phase       = drs_pkg::PH_PRECHECK;
          st_next.fault_latch     = 4'd0;
          st_next.phase_begin_ms  = item.now_ms;
          st_next.run_begin_ms    = '0;
          st_next.run_clock_valid = 1'b0;
          if (item.mode_request == drs_pkg::MD_PRESET) begin
            st_next.remaining_secs = cfg.max_run_seconds;
          end else if (item.mode_request == drs_pkg::MD_MANUAL) begin
            st_next.remaining_secs = cfg.run_seconds;
          end else begin
            st_next.remaining_secs = 24'd0;
          end
        end
      end
      drs_pkg::ACT_PAUSE: begin
        if (st.run_phase inside {drs_pkg::PH_WARMUP, drs_pkg::PH_DRYING, drs_pkg::PH_HOLD}) begin
          st_next.phase_before_pause = st.run_phase;
          st_next.run_phase          = drs_pkg::PH_PAUSED;
          st_next.pause_begin_ms     = item.now_ms;
        end
      end
      drs_pkg::ACT_RESUME: begin
        if (st.run_phase == drs_pkg::PH_PAUSED) begin
          // credit the paused span back to the drying clock
          if (st.run_clock_valid) begin
            st_next.run_begin_ms = st.run_begin_ms + pause_diff;
          end
          st_next.run_phase          = st.phase_before_pause;
          st_next.phase_begin_ms     = item.now_ms;
          st_next.pause_begin_ms     = '0;
          st_next.phase_before_pause = drs_pkg::PH_IDLE;
        end
      end
      drs_pkg::ACT_STOP: begin
        st_next.run_mode       = drs_pkg::MD_IDLE;
        st_next.run_phase      = drs_pkg::PH_COOLDOWN;
        st_next.fault_latch    = 4'd0;
        st_next.phase_begin_ms = item.now_ms;
        st_next.remaining_secs = 24'd0;
      end
      drs_pkg::ACT_FAULT: begin
        st_next.run_mode       = drs_pkg::MD_FAULT;
        st_next.run_phase      = drs_pkg::PH_FAULT;
        st_next.fault_latch    = item.fault_reason;
        st_next.phase_begin_ms = item.now_ms;
      end
      default: begin
      end
    endcase
    res.phase_now    = st_next.run_phase;
    res.mode_now     = st_next.run_mode;
    res.fault_now    = st_next.fault_latch;
    res.seconds_left = st_next.remaining_secs;
  end

endmodule
`default_nettype wire

/* sv/dryer_run_phase_sequencer.sv */
// An accepted input word is held in the event register; its result word is loaded onto m_tdata when it advances.
// Throughput: one word per cycle while m_tready is high; the event register feeds the next-state logic
// and result register, with the state updated in the same cycle.
// Reset (rst, synchronous, active high): idle mode and phase, no fault, all
// times and seconds zero, registers to reset values (dry windows 3), no words held.
`default_nettype none
module dryer_run_phase_sequencer (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], mode_request[34:32], fault_reason[38:35], air_valid[39],
  // air_tenths[51:40], dry_count[59:52], zero[63:60]
  input  logic [63:0] s_tdata,
  // action[2:0]
  input  logic [2:0]  s_tuser,
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  // phase_now[3:0], mode_now[6:4], fault_now[10:7], seconds_left[34:11],
  // start_ok[35], zero[39:36]
  output logic [39:0] m_tdata,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  drs_pkg::item_t   in_item;
  logic             in_full;
  logic             adv;
  drs_pkg::state_t  st;
  drs_pkg::state_t  st_next;
  drs_pkg::cfg_t    cfg;
  drs_pkg::result_t res;
  logic             cfg_wr;

  // handshake
  assign adv      = in_full && (!m_tvalid || m_tready);
  assign s_tready = !in_full || adv;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action       <= drs_pkg::action_t'(s_tuser);
      in_item.now_ms       <= s_tdata[31:0];
      in_item.mode_request <= s_tdata[34:32];
      in_item.fault_reason <= s_tdata[38:35];
      in_item.air_valid    <= s_tdata[39];
      in_item.air_tenths   <= s_tdata[51:40];
      in_item.dry_count    <= s_tdata[59:52];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_seconds        <= 24'd0;
      cfg.min_run_seconds    <= 24'd0;
      cfg.max_run_seconds    <= 24'd0;
      cfg.target_air_tenths  <= 12'sd0;
      cfg.dry_windows_needed <= drs_pkg::DRY_WINDOWS_RESET;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        drs_pkg::REG_RUN_SECONDS:     cfg.run_seconds        <= pwdata[23:0];
        drs_pkg::REG_MIN_RUN_SECONDS: cfg.min_run_seconds    <= pwdata[23:0];
        drs_pkg::REG_MAX_RUN_SECONDS: cfg.max_run_seconds    <= pwdata[23:0];
        drs_pkg::REG_TARGET_AIR:      cfg.target_air_tenths  <= pwdata[11:0];
        drs_pkg::REG_DRY_WINDOWS:     cfg.dry_windows_needed <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[4:2])
      drs_pkg::REG_RUN_SECONDS:     prdata = {8'd0, cfg.run_seconds};
      drs_pkg::REG_MIN_RUN_SECONDS: prdata = {8'd0, cfg.min_run_seconds};
      drs_pkg::REG_MAX_RUN_SECONDS: prdata = {8'd0, cfg.max_run_seconds};
      drs_pkg::REG_TARGET_AIR:      prdata = {20'd0, cfg.target_air_tenths};
      drs_pkg::REG_DRY_WINDOWS:     prdata = {24'd0, cfg.dry_windows_needed};
      default:                      prdata = 32'd0;
    endcase
  end

  drs_step u_step (
    .st      (st),
    .item    (in_item),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.run_mode           <= drs_pkg::MD_IDLE;
      st.run_phase          <= drs_pkg::PH_IDLE;
      st.fault_latch        <= 4'd0;
      st.phase_begin_ms     <= '0;
      st.run_begin_ms       <= '0;
      st.pause_begin_ms     <= '0;
      st.phase_before_pause <= drs_pkg::PH_IDLE;
      st.remaining_secs     <= 24'd0;
      st.run_clock_valid    <= 1'b0;
      st.lat_run            <= 24'd0;
      st.lat_min            <= 24'd0;
      st.lat_max            <= 24'd0;
      st.lat_target         <= 12'sd0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'd0, res.start_ok, res.seconds_left, res.fault_now,
                  res.mode_now, res.phase_now};
    end
  end

  // checks
`include "assert_macros.svh"
  `DRS_ASSERT_IMPL(a_fault_pair, 1'b1, ((st.run_phase == drs_pkg::PH_FAULT) == (st.run_mode == drs_pkg::MD_FAULT)))
  `DRS_ASSERT_IMPL(a_idle_clear, (st.run_mode == drs_pkg::MD_IDLE), (st.remaining_secs == 24'd0))
  `DRS_ASSERT_IMPL(a_stall_hold, (in_full && m_tvalid && !m_tready), (!s_tready))
  `DRS_ASSERT_NEXT(a_start_pre, (adv && res.start_ok), (st.run_phase == drs_pkg::PH_PRECHECK))

endmodule
`default_nettype wire
